>>> rtl/core/jit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jit_pkg - shared types and constants for the joint impedance torque unit
// Item formats, item kinds, slot geometry, memory word layouts and FSM states.
// ----------------------------------------------------------------------------
package jit_pkg;

  localparam int JOINTS_PER_ARM = 7;
  localparam int NUM_ARMS       = 2;
  localparam int SLOT_COUNT     = NUM_ARMS * JOINTS_PER_ARM;
  localparam int SLOT_W         = $clog2(SLOT_COUNT);

  // 1.0 in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_SEED   = 2'd2,
    KIND_STEP   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         slot;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] coriolis_torque;
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic [30:0]        stiffness;
    logic [30:0]        damping;
    logic [30:0]        error_limit;
    logic [16:0]        filter_weight;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_slot;
    logic signed [31:0] torque;
    logic signed [31:0] filtered_position;
    logic signed [31:0] filtered_velocity;
  } out_item_t;

  // gain memory word
  typedef struct packed {
    logic [30:0] stiffness;
    logic [30:0] damping;
    logic [30:0] limit;
    logic [16:0] weight;
  } gain_t;

  // target memory word: raw lane and filtered lane, written separately
  typedef struct packed {
    logic signed [31:0] raw_pos;
    logic signed [31:0] raw_vel;
    logic signed [31:0] filt_pos;
    logic signed [31:0] filt_vel;
  } tgt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLEND,
    ST_FILT,
    ST_ERR,
    ST_MUL,
    ST_SUM
  } state_t;

endpackage

>>> rtl/core/joint_impedance_torque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_impedance_torque_unit - per-joint impedance torque controller
// Slot-addressed gain and target memories with a step sequencer (Q16.16).
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per command. kind LOAD writes a slot's gains, TARGET its
//           raw targets, SEED sets raw and filtered position to the measured
//           position with zero velocities, STEP runs one control update.
//           Items with a slot at or above SLOT_COUNT are taken and dropped.
//   out_* : one result item per in-range STEP: slot, saturated torque and the
//           updated filtered targets.
// Timing:
//   LOAD / TARGET / SEED complete at the accepting edge; in_ready stays high,
//   so these can stream one per cycle.
//   STEP: memories are read at the accepting edge, then BLEND (setpoint
//   multiply), FILT (round, write back), ERR (clamp), MUL (gain multiply),
//   SUM (round, add, saturate). The result is loaded into the output
//   register when SUM ends and in_ready returns the same edge, so a new
//   STEP is taken only once the last one has left SUM, the pace set by
//   the two dependent multiply rounds behind the registered memory read.
// Stall: the output register holds one result. While it is full and not
//   taken, the next STEP result waits in SUM with in_ready low, so no item
//   of any kind is accepted until the held result drains.
// Reset: control state and the target valid bits clear, so all targets
//   read as zero afterwards. Gains are undefined until loaded.
// ----------------------------------------------------------------------------
module joint_impedance_torque_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jit_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jit_pkg::out_item_t out_data
);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  jit_pkg::state_t state_r, state_nxt;

  logic                        accept;
  logic                        slot_ok;
  logic [jit_pkg::SLOT_W-1:0]  acc_idx;
  logic [jit_pkg::SLOT_W-1:0]  step_idx;

  assign in_ready = (state_r == jit_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign slot_ok  = int'(in_data.slot) < jit_pkg::SLOT_COUNT;
  assign acc_idx  = in_data.slot[jit_pkg::SLOT_W-1:0];

  // step item held for the whole sequence
  jit_pkg::in_item_t item_r;
  assign step_idx = item_r.slot[jit_pkg::SLOT_W-1:0];

  logic out_valid_r;
  logic out_load;

  // --------------------------------------------------------------------------
  // Memories: gains (no reset) and targets (raw / filtered lanes)
  // --------------------------------------------------------------------------
  jit_pkg::gain_t gain_mem [jit_pkg::SLOT_COUNT];
  jit_pkg::tgt_t  tgt_mem  [jit_pkg::SLOT_COUNT];

  jit_pkg::gain_t gain_rd_r;
  jit_pkg::tgt_t  tgt_rd_r;
  logic           rd_raw_ok_r;
  logic           rd_filt_ok_r;

  // per-entry valid bits; an entry not yet written reads as zero
  logic [jit_pkg::SLOT_COUNT-1:0] raw_vld_r;
  logic [jit_pkg::SLOT_COUNT-1:0] filt_vld_r;

  logic                       gain_we;
  jit_pkg::gain_t             gain_wdata;
  logic                       raw_we;
  logic                       filt_we;
  logic                       rd_en;
  logic [jit_pkg::SLOT_W-1:0] tgt_widx;
  logic signed [31:0]         raw_pos_w, raw_vel_w, filt_pos_w, filt_vel_w;
  logic signed [31:0]         fp_nxt, fv_nxt;

  assign gain_we = accept && slot_ok && (in_data.kind == jit_pkg::KIND_LOAD);
  assign raw_we  = accept && slot_ok &&
                   (in_data.kind == jit_pkg::KIND_TARGET ||
                    in_data.kind == jit_pkg::KIND_SEED);
  assign filt_we = (accept && slot_ok && in_data.kind == jit_pkg::KIND_SEED) ||
                   (state_r == jit_pkg::ST_FILT);
  assign rd_en   = accept && slot_ok && (in_data.kind == jit_pkg::KIND_STEP);

  always_comb begin
    gain_wdata.stiffness = in_data.stiffness;
    gain_wdata.damping   = in_data.damping;
    gain_wdata.limit     = in_data.error_limit;
    // weight above one is stored as one
    gain_wdata.weight    = (in_data.filter_weight > jit_pkg::ONE_Q16) ?
                           jit_pkg::ONE_Q16 : in_data.filter_weight;
  end

  always_comb begin
    if (in_data.kind == jit_pkg::KIND_SEED) begin
      raw_pos_w = in_data.position;
      raw_vel_w = '0;
    end else begin
      raw_pos_w = in_data.target_position;
      raw_vel_w = in_data.target_velocity;
    end
    // the filter write-back only happens in FILT, when no item is accepted
    if (state_r == jit_pkg::ST_FILT) begin
      tgt_widx   = step_idx;
      filt_pos_w = fp_nxt;
      filt_vel_w = fv_nxt;
    end else begin
      tgt_widx   = acc_idx;
      filt_pos_w = in_data.position;
      filt_vel_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (gain_we) begin
      gain_mem[acc_idx] <= gain_wdata;
    end
    if (raw_we) begin
      tgt_mem[acc_idx].raw_pos <= raw_pos_w;
      tgt_mem[acc_idx].raw_vel <= raw_vel_w;
    end
    if (filt_we) begin
      tgt_mem[tgt_widx].filt_pos <= filt_pos_w;
      tgt_mem[tgt_widx].filt_vel <= filt_vel_w;
    end
    if (rd_en) begin
      gain_rd_r    <= gain_mem[acc_idx];
      tgt_rd_r     <= tgt_mem[acc_idx];
      rd_raw_ok_r  <= raw_vld_r[acc_idx];
      rd_filt_ok_r <= filt_vld_r[acc_idx];
      item_r       <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_vld_r  <= '0;
      filt_vld_r <= '0;
    end else begin
      if (raw_we) begin
        raw_vld_r[acc_idx] <= 1'b1;
      end
      if (filt_we) begin
        filt_vld_r[tgt_widx] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // BLEND: a * (raw - filt) for position and velocity
  // --------------------------------------------------------------------------
  logic signed [31:0] raw_p, raw_v, filt_p, filt_v;
  logic signed [32:0] diff_p, diff_v;
  logic signed [17:0] alpha_s;
  logic signed [50:0] mp_nxt, mv_nxt;
  logic signed [50:0] mp_r, mv_r;

  assign raw_p   = rd_raw_ok_r  ? tgt_rd_r.raw_pos  : '0;
  assign raw_v   = rd_raw_ok_r  ? tgt_rd_r.raw_vel  : '0;
  assign filt_p  = rd_filt_ok_r ? tgt_rd_r.filt_pos : '0;
  assign filt_v  = rd_filt_ok_r ? tgt_rd_r.filt_vel : '0;
  assign diff_p  = {raw_p[31], raw_p} - {filt_p[31], filt_p};
  assign diff_v  = {raw_v[31], raw_v} - {filt_v[31], filt_v};
  assign alpha_s = $signed({1'b0, gain_rd_r.weight});
  assign mp_nxt  = alpha_s * diff_p;
  assign mv_nxt  = alpha_s * diff_v;

  // --------------------------------------------------------------------------
  // FILT: filt + round(a*diff / 2^16); equals the rounded convex blend
  // --------------------------------------------------------------------------
  logic signed [50:0] mp_rnd, mv_rnd;
  logic signed [34:0] fp_full, fv_full;
  logic signed [31:0] fp_r, fv_r;

  assign mp_rnd  = mp_r + 51'sd32768;
  assign mv_rnd  = mv_r + 51'sd32768;
  assign fp_full = {{3{filt_p[31]}}, filt_p} + $signed(mp_rnd[50:16]);
  assign fv_full = {{3{filt_v[31]}}, filt_v} + $signed(mv_rnd[50:16]);
  assign fp_nxt  = fp_full[31:0];
  assign fv_nxt  = fv_full[31:0];

  // --------------------------------------------------------------------------
  // ERR: clamped position error, velocity error
  // --------------------------------------------------------------------------
  logic signed [32:0] e_full, lim_p, lim_n, e_clamp, ve_nxt;
  logic signed [31:0] e_r;
  logic signed [32:0] ve_r;

  assign e_full = {fp_r[31], fp_r} - {item_r.position[31], item_r.position};
  assign lim_p  = $signed({2'b00, gain_rd_r.limit});
  assign lim_n  = -lim_p;
  assign ve_nxt = {fv_r[31], fv_r} - {item_r.velocity[31], item_r.velocity};

  always_comb begin
    if (e_full > lim_p) begin
      e_clamp = lim_p;
    end else if (e_full < lim_n) begin
      e_clamp = lim_n;
    end else begin
      e_clamp = e_full;
    end
  end

  // --------------------------------------------------------------------------
  // MUL: K*e and D*ve
  // --------------------------------------------------------------------------
  logic signed [63:0] pk_nxt, pk_r;
  logic signed [64:0] pd_nxt, pd_r;

  assign pk_nxt = $signed({1'b0, gain_rd_r.stiffness}) * e_r;
  assign pd_nxt = $signed({1'b0, gain_rd_r.damping}) * ve_r;

  // --------------------------------------------------------------------------
  // SUM: round both products, add Coriolis torque, saturate
  // --------------------------------------------------------------------------
  logic signed [63:0] pk_rnd;
  logic signed [64:0] pd_rnd;
  logic signed [50:0] tq_full;
  logic signed [31:0] tq_sat;

  assign pk_rnd  = pk_r + 64'sd32768;
  assign pd_rnd  = pd_r + 65'sd32768;
  assign tq_full = {{3{pk_rnd[63]}}, pk_rnd[63:16]} +
                   {{2{pd_rnd[64]}}, pd_rnd[64:16]} +
                   {{19{item_r.coriolis_torque[31]}}, item_r.coriolis_torque};

  always_comb begin
    // in range only when bits 50..31 all equal the sign
    if (&tq_full[50:31] || ~|tq_full[50:31]) begin
      tq_sat = tq_full[31:0];
    end else if (tq_full[50]) begin
      tq_sat = jit_pkg::SAT_MIN;
    end else begin
      tq_sat = jit_pkg::SAT_MAX;
    end
  end

  // datapath registers, loaded in their own stage
  always_ff @(posedge clk) begin
    if (state_r == jit_pkg::ST_BLEND) begin
      mp_r <= mp_nxt;
      mv_r <= mv_nxt;
    end
    if (state_r == jit_pkg::ST_FILT) begin
      fp_r <= fp_nxt;
      fv_r <= fv_nxt;
    end
    if (state_r == jit_pkg::ST_ERR) begin
      e_r  <= e_clamp[31:0];
      ve_r <= ve_nxt;
    end
    if (state_r == jit_pkg::ST_MUL) begin
      pk_r <= pk_nxt;
      pd_r <= pd_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jit_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      jit_pkg::ST_IDLE: begin
        if (rd_en) begin
          state_nxt = jit_pkg::ST_BLEND;
        end
      end
      jit_pkg::ST_BLEND: state_nxt = jit_pkg::ST_FILT;
      jit_pkg::ST_FILT:  state_nxt = jit_pkg::ST_ERR;
      jit_pkg::ST_ERR:   state_nxt = jit_pkg::ST_MUL;
      jit_pkg::ST_MUL:   state_nxt = jit_pkg::ST_SUM;
      jit_pkg::ST_SUM: begin
        // wait here while the output register is full and stalled
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = jit_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jit_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  jit_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_slot          <= item_r.slot;
      out_data_r.torque            <= tq_sat;
      out_data_r.filtered_position <= fp_r;
      out_data_r.filtered_velocity <= fv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/jit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jit_checker - port-level checks for the joint impedance torque unit
// Watches the item handshakes and the step sequencing seen at the ports.
// ----------------------------------------------------------------------------
module jit_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input jit_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input jit_pkg::out_item_t out_data
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or dropped while stalled");

  // non-step kinds finish at the accepting edge
  a_short_kind: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind != jit_pkg::KIND_STEP |=> in_ready)
    else $error("non-step item blocked the input");

  // an in-range step occupies the unit
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.kind == jit_pkg::KIND_STEP &&
    int'(in_data.slot) < jit_pkg::SLOT_COUNT |=> !in_ready)
    else $error("step item did not occupy the unit");

  // results only carry valid slots
  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_data.out_slot) < jit_pkg::SLOT_COUNT)
    else $error("result item with out-of-range slot");

endmodule

bind joint_impedance_torque_unit jit_checker u_jit_checker (.*);
